>>> hw/rtl/gfl_pkg.sv
// shared types and constants for the gf(2^m) lagrange coefficient block
`timescale 1ns / 1ps
package gfl_pkg;
  localparam int FieldBits = 16;
  localparam int MaxPoints = 16;
  localparam int IdxBits = $clog2(MaxPoints);
  localparam int CntBits = $clog2(MaxPoints + 1);
  localparam int BitCntBits = $clog2(FieldBits);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_OVF = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [15:0] PolyReset = 16'd4107;

  typedef logic [FieldBits-1:0] elem_t;

  typedef struct packed {
    logic  start;
    elem_t a;
    elem_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    elem_t p;
  } mul_rsp_t;
endpackage

>>> hw/rtl/gfl_if.sv
// request, result and config channels of the lagrange coefficient block
`timescale 1ns / 1ps
interface gfl_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [15:0] value;
  modport source(output valid, op, value, input ready);
  modport sink(input valid, op, value, output ready);
endinterface

interface gfl_out_if;
  logic valid;
  logic ready;
  logic [15:0] coefficient;
  logic [3:0] point_index;
  logic [1:0] status;
  logic last;
  modport source(output valid, coefficient, point_index, status, last, input ready);
  modport sink(input valid, coefficient, point_index, status, last, output ready);
endinterface

interface gfl_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> hw/rtl/gfl_ram.sv
// generic single-port write, single read ram with registered read
`timescale 1ns / 1ps
module gfl_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/gfl_mul.sv
// bit-serial gf(2^m) multiplier, one bit of b per cycle, msb first
`timescale 1ns / 1ps
module gfl_mul import gfl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  elem_t    poly,
  input  mul_req_t req,
  output mul_rsp_t rsp
);
  logic busy;
  logic done;
  elem_t a, b, acc;
  logic [BitCntBits-1:0] cnt;
  elem_t acc_next;

  always_comb begin
    acc_next = {acc[FieldBits-2:0], 1'b0};
    if (acc[FieldBits-1]) acc_next = acc_next ^ poly;
    if (b[FieldBits-1]) acc_next = acc_next ^ a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && cnt == BitCntBits'(FieldBits - 1);
      if (req.start) begin
        busy <= 1'b1;
        a <= req.a;
        b <= req.b;
        acc <= '0;
        cnt <= '0;
      end else if (busy) begin
        acc <= acc_next;
        b <= {b[FieldBits-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == BitCntBits'(FieldBits - 1)) busy <= 1'b0;
      end
    end
  end

  // product sits in acc once the last bit has been taken
  assign rsp = {done, acc};
endmodule

>>> hw/rtl/gf2m_lagrange_coefficients_core.sv
// top level of the gf(2^m) lagrange coefficient block
// usage:
//   in channel: op=0 stores value as the next point (up to 16), no result;
//   op=1 computes coefficients at value, and clears the store.
//   out channel: one error/empty result (status 3 overflow, 2 no points,
//   1 duplicate) or one result per point with last on the final one.
//   cfg channel: writes the low bits of the reduction polynomial; take
//   it only while the block is idle.
// operation: an overflow or empty result is out in the cycle after its
//   request. with n points a compute first scans the store for duplicates,
//   then each point needs 2*(n-1) products, 15 squarings and 15 products
//   for the inverse and one final product on the one shared bit-serial
//   multiplier.
// throughput: one request at a time; the next is taken once the block is
//   idle and its last result has been taken.
// reset: store empty, overflow clear, polynomial 0x100b, no clearing pass.
// a stall on the out channel holds the waiting result; the sequencer goes
//   on with the next point and waits before it would replace it.
`timescale 1ns / 1ps
module gf2m_lagrange_coefficients_core import gfl_pkg::*; (
  input logic clk,
  input logic rst,
  gfl_in_if.sink in,
  gfl_out_if.source out,
  gfl_cfg_if.sink cfg
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DRD = 4'd1, S_DWAIT = 4'd2,
    S_DCMP = 4'd3, S_PRD = 4'd4, S_PWAIT = 4'd5, S_MUL = 4'd6,
    S_MWAIT = 4'd7, S_OUT = 4'd8, S_XRD = 4'd9, S_XWAIT = 4'd10,
    S_URD = 4'd11;

  // multiply phases for one point
  localparam logic [2:0] P_TOP = 3'd0, P_BOT = 3'd1, P_SQ = 3'd2,
    P_INV = 3'd3, P_FIN = 3'd4;

  logic [3:0] state;
  logic [CntBits-1:0] count;
  logic ovf;
  elem_t poly, beta, ym, yu, top, bot, t, r, fin;
  logic [IdxBits-1:0] i, u, raddr;
  logic [2:0] phase;
  logic [BitCntBits-1:0] k;
  elem_t rdata;
  logic we;
  logic res_emit;
  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic [15:0] o_coef;
  logic [3:0] o_idx;
  logic [1:0] o_st;
  logic o_last;
  logic o_valid;

  assign cfg.ready = 1'b1;
  assign in.ready = (state == S_IDLE) && !o_valid;
  assign we = in.valid && in.ready && in.op == OP_LOAD
              && count < CntBits'(MaxPoints);

  gfl_ram #(.Width(FieldBits), .Depth(MaxPoints)) u_store (
    .clk(clk), .we(we), .waddr(count[IdxBits-1:0]), .wdata(in.value),
    .raddr(raddr), .rdata(rdata));

  gfl_mul u_mul (.clk(clk), .rst(rst), .poly(poly), .req(mreq), .rsp(mrsp));

  assign out.valid = o_valid;
  assign out.coefficient = o_coef;
  assign out.point_index = o_idx;
  assign out.status = o_st;
  assign out.last = o_last;

  logic [IdxBits-1:0] nlast;
  assign nlast = IdxBits'(count - 1'b1);

  // a result register is loaded only while it is empty
  assign res_emit = (state == S_IDLE && in.valid && in.ready
                     && in.op == OP_COMPUTE && (ovf || count == '0))
                    || (state == S_DCMP && rdata == ym)
                    || (state == S_OUT && !o_valid);

  always_comb begin
    mreq.start = 1'b0;
    mreq.a = top;
    mreq.b = beta ^ yu;
    if (state == S_MUL) begin
      mreq.start = 1'b1;
      case (phase)
        P_TOP: begin mreq.a = top; mreq.b = beta ^ yu; end
        P_BOT: begin mreq.a = bot; mreq.b = ym ^ yu; end
        P_SQ: begin mreq.a = t; mreq.b = t; end
        P_INV: begin mreq.a = r; mreq.b = t; end
        default: begin mreq.a = top; mreq.b = r; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf <= 1'b0;
      poly <= PolyReset;
      o_valid <= 1'b0;
    end else begin
      if (cfg.valid) poly <= cfg.data;
      if (res_emit) o_valid <= 1'b1;
      else if (out.ready) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in.valid && in.ready) begin
            if (in.op == OP_LOAD) begin
              if (count < CntBits'(MaxPoints)) count <= count + 1'b1;
              else ovf <= 1'b1;
            end else begin
              beta <= in.value;
              o_coef <= '0; o_idx <= '0; o_last <= 1'b1;
              if (ovf) begin
                o_st <= ST_OVF; ovf <= 1'b0; count <= '0;
              end else if (count == '0) begin
                o_st <= ST_EMPTY;
              end else begin
                i <= '0; raddr <= '0; state <= S_DRD;
              end
            end
          end
        end
        // duplicate scan: ym=store[i], compare with store[u] for u>i
        S_DRD: state <= S_DWAIT;
        S_DWAIT: begin
          ym <= rdata;
          if (i == nlast) begin
            i <= '0; raddr <= '0; state <= S_XRD;
          end else begin
            u <= i + 1'b1; raddr <= i + 1'b1; state <= S_PRD;
          end
        end
        S_PRD: state <= S_DCMP;
        S_DCMP: begin
          if (rdata == ym) begin
            o_st <= ST_DUP; count <= '0; state <= S_IDLE;
          end else if (u == nlast) begin
            i <= i + 1'b1; raddr <= i + 1'b1; state <= S_DRD;
          end else begin
            u <= u + 1'b1; raddr <= u + 1'b1; state <= S_PRD;
          end
        end
        // per point: fetch ym
        S_XRD: state <= S_XWAIT;
        S_XWAIT: begin
          ym <= rdata; top <= elem_t'(1); bot <= elem_t'(1);
          u <= '0; raddr <= '0; state <= S_URD;
        end
        // product loop over the other points
        S_URD: state <= S_PWAIT;
        S_PWAIT: begin
          yu <= rdata;
          if (u != i) begin
            phase <= P_TOP; state <= S_MUL;
          end else if (u == nlast) begin
            t <= bot; r <= elem_t'(1); k <= '0; phase <= P_SQ; state <= S_MUL;
          end else begin
            u <= u + 1'b1; raddr <= u + 1'b1; state <= S_URD;
          end
        end
        S_MUL: state <= S_MWAIT;
        S_MWAIT: begin
          if (mrsp.done) begin
            case (phase)
              P_TOP: begin top <= mrsp.p; phase <= P_BOT; state <= S_MUL; end
              P_BOT: begin
                bot <= mrsp.p;
                if (u == nlast) begin
                  t <= mrsp.p; r <= elem_t'(1); k <= '0; phase <= P_SQ;
                  state <= S_MUL;
                end else begin
                  u <= u + 1'b1; raddr <= u + 1'b1; state <= S_URD;
                end
              end
              P_SQ: begin t <= mrsp.p; phase <= P_INV; state <= S_MUL; end
              P_INV: begin
                r <= mrsp.p;
                if (k == BitCntBits'(FieldBits - 2)) phase <= P_FIN;
                else begin k <= k + 1'b1; phase <= P_SQ; end
                state <= S_MUL;
              end
              default: begin fin <= mrsp.p; state <= S_OUT; end
            endcase
          end
        end
        S_OUT: begin
          if (!o_valid) begin
            o_coef <= fin; o_idx <= 4'(i); o_st <= ST_OK;
            o_last <= (i == nlast);
            if (i == nlast) begin
              count <= '0; state <= S_IDLE;
            end else begin
              i <= i + 1'b1; raddr <= i + 1'b1; state <= S_XRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/gfl_checker.sv
// port-level checks for the lagrange coefficient block, bound to the top
`timescale 1ns / 1ps
module gfl_checker import gfl_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_coefficient,
  input logic [1:0] out_status,
  input logic [3:0] out_point_index
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_coefficient))
    else $error("result dropped under stall");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_coefficient == 16'd0
    && out_point_index == 4'd0)
    else $error("error result carries data");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");
endmodule

bind gf2m_lagrange_coefficients_core gfl_checker u_gfl_checker (
  .clk(clk), .rst(rst), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .out_coefficient(out.coefficient), .out_status(out.status),
  .out_point_index(out.point_index));
